### rtl/sfr_pkg.sv
// Shared types and constants of the stream find-and-replace block.
// Used by the channel interfaces, the window cells, the emitter and the top level.
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;

    localparam int DEF_MAX_PATTERN     = 16;
    localparam int DEF_MAX_REPLACEMENT = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd5;

    // Control handed to every window cell.
    typedef struct packed {
        logic             append;
        logic             shift;
        logic [LEN_W-1:0] fill;
    } win_ctl_t;

    // Description of a run of result beats loaded into the emitter.
    typedef struct packed {
        logic [LEN_W-1:0] count;
        logic             byte_valid;
        logic             eos;
    } burst_t;

endpackage

`default_nettype wire

### rtl/sfr_in_if.sv
// Input channel of the find-and-replace block: one source byte or an end marker a beat.
// Depends on sfr_pkg for the byte width.
`default_nettype none

interface sfr_in_if;
    logic                      valid;
    logic                      ready;
    logic [sfr_pkg::BYTE_W-1:0] char_in;
    logic                      end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

`default_nettype wire

### rtl/sfr_out_if.sv
// Result channel of the find-and-replace block: one output byte or end marker a beat.
// Depends on sfr_pkg for the byte width.
`default_nettype none

interface sfr_out_if;
    logic                      valid;
    logic                      ready;
    logic [sfr_pkg::BYTE_W-1:0] byte_out;
    logic                      byte_valid;
    logic                      last_of_run;
    logic                      end_of_string;

    modport source (output valid, output byte_out, output byte_valid, output last_of_run,
                    output end_of_string, input ready);
    modport sink   (input valid, input byte_out, input byte_valid, input last_of_run,
                    input end_of_string, output ready);
endinterface

`default_nettype wire

### rtl/sfr_cfg_if.sv
// Configuration write channel of the find-and-replace block.
// Depends on sfr_pkg for the index and data widths.
`default_nettype none

interface sfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::CFG_IDX_W-1:0] index;
    logic [sfr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/stream_find_and_replace.sv
// Streaming find-and-replace: a row of window cells tracks the held bytes and matches them
// against the pattern; an emitter turns each decision into a run of result beats.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_cfg_if, sfr_win_cell and sfr_emitter.
//
// Use: write the pattern, its length, the replacement and its length on the cfg channel
// (always ready, one register a beat) while the block is idle. Then send the string on the
// text channel, one byte a beat, closed by a beat with end_of_input set. Each text beat
// yields from zero to sixteen beats on the result channel; the last of them carries
// last_of_run, and the last beat of a flush also carries end_of_string. A flush of an
// empty window gives one bare beat with byte_valid low.
// An accepted text beat loads its beats into the emitter's shift line, from which they
// move in order into the output register, one beat a cycle unless the receiver stalls.
// An item that yields at most one beat is taken every cycle while result.ready stays
// high; a longer run holds the text channel until the emitter is on its last beat, where
// text.ready follows result.ready. A stalled receiver keeps the output register full;
// items are still taken until one with beats fills the line. Reset empties the window
// and the emitter, and sets the pattern length to one and the replacement length to zero.
`default_nettype none

module stream_find_and_replace #(
    parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
    input  wire        clk,
    input  wire        rst_n,
    sfr_in_if.sink     text,
    sfr_out_if.source  result,
    sfr_cfg_if.sink    cfg
);
    import sfr_pkg::*;

    localparam int FILL_W      = $clog2(MAX_PATTERN);
    localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
    localparam int BURST_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                 : MAX_REPLACEMENT;

    logic [CFG_DATA_W-1:0] pat_lo_reg;
    logic [CFG_DATA_W-1:0] pat_hi_reg;
    logic [LEN_W-1:0]      plen_cfg_reg;
    logic [CFG_DATA_W-1:0] rep_lo_reg;
    logic [CFG_DATA_W-1:0] rep_hi_reg;
    logic [LEN_W-1:0]      rlen_cfg_reg;

    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;

    logic [2*CFG_DATA_W-1:0] pat_all;
    logic [2*CFG_DATA_W-1:0] rep_all;
    logic [PLEN_W-1:0]       plen_eff;
    logic [LEN_W-1:0]        rlen_eff;
    logic [LEN_W-1:0]        fill_x;
    logic [LEN_W-1:0]        plen_x;

    logic acc;
    logic take_ok;
    logic is_end;
    logic shrunk;
    logic complete;
    logic all_eq;
    logic match;
    logic do_append;

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_q;
    logic [MAX_PATTERN-1:0]             eq_vec;
    logic [MAX_PATTERN-1:0]             in_use;
    win_ctl_t                           wctl;

    burst_t                             burst;
    logic [BURST_DEPTH-1:0][BYTE_W-1:0] burst_bytes;
    logic                               load;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg   <= '0;
            pat_hi_reg   <= '0;
            plen_cfg_reg <= LEN_W'(1);
            rep_lo_reg   <= '0;
            rep_hi_reg   <= '0;
            rlen_cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PATTERN_LOW:        pat_lo_reg   <= cfg.data;
                REG_PATTERN_HIGH:       pat_hi_reg   <= cfg.data;
                REG_PATTERN_LENGTH:     plen_cfg_reg <= cfg.data[LEN_W-1:0];
                REG_REPLACEMENT_LOW:    rep_lo_reg   <= cfg.data;
                REG_REPLACEMENT_HIGH:   rep_hi_reg   <= cfg.data;
                REG_REPLACEMENT_LENGTH: rlen_cfg_reg <= cfg.data[LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    assign pat_all = {pat_hi_reg, pat_lo_reg};
    assign rep_all = {rep_hi_reg, rep_lo_reg};

    always_comb
    begin
        if (plen_cfg_reg == '0)
        begin
            plen_eff = PLEN_W'(1);
        end
        else if (plen_cfg_reg > LEN_W'(MAX_PATTERN))
        begin
            plen_eff = PLEN_W'(MAX_PATTERN);
        end
        else
        begin
            plen_eff = plen_cfg_reg[PLEN_W-1:0];
        end
    end

    assign rlen_eff = (rlen_cfg_reg > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT)
                                                               : rlen_cfg_reg;

    // Decision for the byte on the text channel.
    assign acc    = text.valid && take_ok;
    assign fill_x = LEN_W'(fill_reg);
    assign plen_x = LEN_W'(plen_eff);
    assign is_end = text.end_of_input;
    // After the pattern has been shortened the held bytes can reach its length; they are
    // then passed through unmatched together with the new byte.
    assign shrunk    = !is_end && (fill_x >= plen_x);
    assign complete  = !is_end && !shrunk && ((fill_x + LEN_W'(1)) == plen_x);
    assign all_eq    = &(eq_vec | ~in_use);
    assign match     = complete && all_eq;
    assign do_append = !is_end && !shrunk && !complete;

    assign wctl.append = acc && do_append;
    assign wctl.shift  = acc && complete && !all_eq;
    assign wctl.fill   = fill_x;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            assign in_use[k] = LEN_W'(k) < plen_x;

            sfr_win_cell #(
                .K (k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (wctl),
                .char_in  (text.char_in),
                .nbr_byte ((k == MAX_PATTERN - 1) ? {BYTE_W{1'b0}} :
                                                    win_q[(k + 1) % MAX_PATTERN]),
                .pat_byte (pat_all[BYTE_W*k +: BYTE_W]),
                .byte_q   (win_q[k]),
                .eq       (eq_vec[k])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (acc)
        begin
            if (is_end || shrunk || match)
            begin
                fill_next = '0;
            end
            else if (do_append)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Run of result beats for this byte.
    always_comb
    begin
        burst.byte_valid = !(is_end && (fill_x == '0));
        burst.eos        = is_end;
        if (is_end)
        begin
            burst.count = (fill_x == '0) ? LEN_W'(1) : fill_x;
        end
        else if (shrunk)
        begin
            burst.count = fill_x + LEN_W'(1);
        end
        else if (match)
        begin
            burst.count = rlen_eff;
        end
        else if (complete)
        begin
            burst.count = LEN_W'(1);
        end
        else
        begin
            burst.count = '0;
        end
    end

    // Held bytes first, the arriving byte after them; on a match the replacement instead.
    generate
        for (k = 0; k < BURST_DEPTH; k++)
        begin : g_burst
            logic [BYTE_W-1:0] rep_b;
            logic [BYTE_W-1:0] win_b;

            if (k < MAX_REPLACEMENT)
            begin : g_rep
                assign rep_b = rep_all[BYTE_W*k +: BYTE_W];
            end
            else
            begin : g_norep
                assign rep_b = '0;
            end

            if (k < MAX_PATTERN)
            begin : g_win
                assign win_b = (LEN_W'(k) < fill_x) ? win_q[k] : text.char_in;
            end
            else
            begin : g_nowin
                assign win_b = text.char_in;
            end

            assign burst_bytes[k] = match ? rep_b : win_b;
        end
    endgenerate

    assign load       = acc && (burst.count != '0);
    assign text.ready = take_ok;

    sfr_emitter #(
        .BURST_DEPTH (BURST_DEPTH)
    ) u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .burst       (burst),
        .burst_bytes (burst_bytes),
        .take_ok     (take_ok),
        .result      (result)
    );

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        acc && is_end |=> fill_reg == '0)
        else $error("window not emptied by an end beat");

    a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
        acc && match |=> fill_reg == '0)
        else $error("window not emptied after a match");

    a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !is_end && !shrunk |=> LEN_W'(fill_reg) < $past(plen_x))
        else $error("window holds a full pattern length after a byte");

endmodule

`default_nettype wire

### rtl/sfr_win_cell.sv
// One window cell: holds a byte, compares it or the arriving byte with its pattern byte.
// Depends on sfr_pkg for the control struct and widths.
`default_nettype none

module sfr_win_cell #(
    parameter int K = 0
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire sfr_pkg::win_ctl_t     ctl,
    input  wire [sfr_pkg::BYTE_W-1:0]  char_in,
    input  wire [sfr_pkg::BYTE_W-1:0]  nbr_byte,
    input  wire [sfr_pkg::BYTE_W-1:0]  pat_byte,
    output logic [sfr_pkg::BYTE_W-1:0] byte_q,
    output logic                       eq
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              held;

    // A cell below the fill count holds a byte; the cell at the fill count sees the
    // arriving byte.
    assign held = LEN_W'(K) < ctl.fill;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.shift)
        begin
            byte_next = (LEN_W'(K + 1) == ctl.fill) ? char_in : nbr_byte;
        end
        else if (ctl.append && (LEN_W'(K) == ctl.fill))
        begin
            byte_next = char_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_q = byte_reg;
    assign eq     = (held ? byte_reg : char_in) == pat_byte;

endmodule

`default_nettype wire

### rtl/sfr_emitter.sv
// Result emitter: a shift line of pending result bytes feeding a registered output stage.
// Depends on sfr_pkg and the sfr_out_if interface.
`default_nettype none

module sfr_emitter #(
    parameter int BURST_DEPTH = sfr_pkg::DEF_MAX_PATTERN
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         load,
    input  wire sfr_pkg::burst_t                        burst,
    input  wire [BURST_DEPTH-1:0][sfr_pkg::BYTE_W-1:0]  burst_bytes,
    output logic                                        take_ok,
    sfr_out_if.source                                   result
);
    import sfr_pkg::*;

    logic [BURST_DEPTH-1:0][BYTE_W-1:0] line_reg;
    logic [BURST_DEPTH-1:0][BYTE_W-1:0] line_next;
    logic [LEN_W-1:0]                   rem_reg;
    logic [LEN_W-1:0]                   rem_next;
    logic                               bv_reg;
    logic                               eos_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_bv_reg;
    logic              out_last_reg;
    logic              out_eos_reg;
    logic              move;

    // A beat moves into the output stage whenever that stage is empty or being emptied.
    assign move    = (rem_reg != '0) && (!out_valid_reg || result.ready);
    assign take_ok = (rem_reg == '0) || ((rem_reg == LEN_W'(1)) && move);

    always_comb
    begin
        line_next = line_reg;
        rem_next  = rem_reg;
        if (load)
        begin
            line_next = burst_bytes;
            rem_next  = burst.count;
        end
        else if (move)
        begin
            for (int k = 0; k < BURST_DEPTH - 1; k++)
            begin
                line_next[k] = line_reg[k + 1];
            end
            line_next[BURST_DEPTH - 1] = '0;
            rem_next = rem_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
            rem_reg  <= '0;
            bv_reg   <= 1'b0;
            eos_reg  <= 1'b0;
        end
        else
        begin
            line_reg <= line_next;
            rem_reg  <= rem_next;
            if (load)
            begin
                bv_reg  <= burst.byte_valid;
                eos_reg <= burst.eos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_bv_reg    <= 1'b0;
            out_last_reg  <= 1'b0;
            out_eos_reg   <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
            out_byte_reg  <= bv_reg ? line_reg[0] : '0;
            out_bv_reg    <= bv_reg;
            out_last_reg  <= rem_reg == LEN_W'(1);
            out_eos_reg   <= eos_reg && (rem_reg == LEN_W'(1));
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.byte_out      = out_byte_reg;
    assign result.byte_valid    = out_bv_reg;
    assign result.last_of_run   = out_last_reg;
    assign result.end_of_string = out_eos_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= LEN_W'(BURST_DEPTH))
        else $error("emitter holds more beats than its shift line");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> take_ok)
        else $error("burst loaded over pending beats");

    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_eos_reg |-> out_last_reg)
        else $error("end of string flagged on a beat that is not last of its run");

endmodule

`default_nettype wire
